[hw/rtl/dkrf_pkg.sv]
package dkrf_pkg;

  localparam int WordW = 12;
  localparam int CountW = 13;

  // operation codes (pending operation and start_op)
  localparam logic [2:0] OP_IDLE  = 3'd0;
  localparam logic [2:0] OP_READ  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_CHECK = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  // step kinds
  localparam logic KIND_IOT    = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // I/O instruction codes
  localparam logic [WordW-1:0] IOT_LOAD_CMD  = 12'o6732;
  localparam logic [WordW-1:0] IOT_GO_READ   = 12'o6733;
  localparam logic [WordW-1:0] IOT_RD_DA     = 12'o6734;
  localparam logic [WordW-1:0] IOT_GO_WRITE  = 12'o6735;
  localparam logic [WordW-1:0] IOT_RD_CMD    = 12'o6736;
  localparam logic [WordW-1:0] IOT_GO_CHECK  = 12'o6737;
  localparam logic [WordW-1:0] IOT_RD_STAT   = 12'o6741;
  localparam logic [WordW-1:0] IOT_CLR_STAT  = 12'o6742;
  localparam logic [WordW-1:0] IOT_SKIP_DONE = 12'o6745;
  localparam logic [WordW-1:0] IOT_SKIP_ERR  = 12'o6747;
  localparam logic [WordW-1:0] IOT_CLR_ALL   = 12'o6751;
  localparam logic [WordW-1:0] IOT_RD_WC     = 12'o6752;
  localparam logic [WordW-1:0] IOT_LOAD_WC   = 12'o6753;
  localparam logic [WordW-1:0] IOT_LOAD_MA   = 12'o6755;
  localparam logic [WordW-1:0] IOT_RD_MA     = 12'o6757;

  // status words
  localparam logic [WordW-1:0] ST_BUSY      = 12'o0001;
  localparam logic [WordW-1:0] ST_BUSY_VIOL = 12'o1000;
  localparam logic [WordW-1:0] ST_DONE      = 12'o2000;
  localparam logic [WordW-1:0] ST_TRACK_ERR = 12'o6040;
  localparam logic [WordW-1:0] ST_RATE_ERR  = 12'o6100;
  localparam logic [WordW-1:0] ST_SEL_ERR   = 12'o6002;
  localparam logic [WordW-1:0] ST_WLOCK_ERR = 12'o6010;
  localparam logic [WordW-1:0] ST_PAR_ERR   = 12'o6200;

  localparam int BIT_BUSY    = 0;
  localparam int BIT_NO_XFER = 7;
  localparam int BIT_VIOL    = 9;
  localparam int BIT_DONE    = 10;
  localparam int BIT_ERR     = 11;

  localparam logic [CountW-1:0] NBLKS      = 13'd3248;
  localparam logic [CountW-1:0] FULL_COUNT = 13'd4096;

  // config register indexes
  localparam logic CFG_DRIVE_PRESENT = 1'b0;
  localparam logic CFG_WRITE_LOCK    = 1'b1;

  typedef struct packed {
    logic              command;
    logic [WordW-1:0]  opcode;
    logic [WordW-1:0]  bus_data;
    logic              disk_fault;
    logic [CountW-1:0] words_done;
  } item_t;

  typedef struct packed {
    logic [WordW-1:0] ac_out;
    logic             skip;
    logic             unsupported;
    logic             irq;
    logic             busy_res;
    logic [2:0]       start_op;
  } res_t;

endpackage

[hw/rtl/dkrf_core.sv]
module dkrf_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  dkrf_pkg::item_t   itm,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [3:0]        cfg_data,
  output dkrf_pkg::res_t    res
);

  logic [3:0]  drive_mask;
  logic [3:0]  wlock_mask;
  logic [11:0] cmd_reg, cmd_reg_next;
  logic [11:0] disk_addr, disk_addr_next;
  logic [11:0] mem_addr, mem_addr_next;
  logic [11:0] neg_wc, neg_wc_next;
  logic [11:0] status, status_next;
  logic        irq_flag, irq_flag_next;
  logic [2:0]  pending, pending_next;

  logic [12:0] wcnt;
  logic [4:0]  blocks;
  logic [12:0] blk_end;
  logic [13:0] ma_end;
  logic [1:0]  drive;
  logic        busy;
  logic        err;
  logic [11:0] st_keep;
  logic [12:0] moved;
  logic        wlock_hit;

  assign busy    = status[dkrf_pkg::BIT_BUSY];
  assign err     = status[dkrf_pkg::BIT_ERR];
  assign st_keep = status & dkrf_pkg::ST_BUSY_VIOL;
  assign drive   = cmd_reg[2:1];

  // zero count means a full 4096 words
  assign wcnt    = dkrf_pkg::FULL_COUNT - {1'b0, neg_wc};
  assign blocks  = 5'((wcnt + 13'd255) >> 8);
  assign blk_end = {1'b0, disk_addr} + {8'b0, blocks};
  assign ma_end  = {2'b0, mem_addr} + {1'b0, wcnt};

  assign wlock_hit = (pending == dkrf_pkg::OP_WRITE) && wlock_mask[drive];

  always_comb begin
    if (wlock_hit) begin
      moved = '0;
    end else if (itm.disk_fault && (itm.words_done < wcnt)) begin
      moved = itm.words_done;
    end else begin
      moved = wcnt;
    end
  end

  always_comb begin
    cmd_reg_next   = cmd_reg;
    disk_addr_next = disk_addr;
    mem_addr_next  = mem_addr;
    neg_wc_next    = neg_wc;
    status_next    = status;
    irq_flag_next  = irq_flag;
    pending_next   = pending;
    res.ac_out      = itm.bus_data;
    res.skip        = 1'b0;
    res.unsupported = 1'b0;
    res.start_op    = dkrf_pkg::OP_IDLE;

    if (itm.command == dkrf_pkg::KIND_FINISH) begin
      res.ac_out = '0;
      case (pending)
        dkrf_pkg::OP_READ, dkrf_pkg::OP_WRITE, dkrf_pkg::OP_CHECK: begin
          if (blk_end > dkrf_pkg::NBLKS) begin
            status_next = st_keep | dkrf_pkg::ST_TRACK_ERR;
          end else if (ma_end > {1'b0, dkrf_pkg::FULL_COUNT}) begin
            status_next = st_keep | dkrf_pkg::ST_RATE_ERR;
          end else if (!drive_mask[drive]) begin
            status_next = st_keep | dkrf_pkg::ST_SEL_ERR;
          end else begin
            status_next = st_keep | dkrf_pkg::ST_DONE;
            if (!cmd_reg[dkrf_pkg::BIT_NO_XFER]) begin
              if (wlock_hit) begin
                status_next = st_keep | dkrf_pkg::ST_WLOCK_ERR;
              end else if (itm.disk_fault) begin
                status_next = st_keep | dkrf_pkg::ST_PAR_ERR;
              end
              disk_addr_next = disk_addr + {7'b0, moved[12:8]};
              mem_addr_next  = mem_addr + moved[11:0];
              neg_wc_next    = neg_wc + moved[11:0];
            end
          end
          irq_flag_next = (cmd_reg[dkrf_pkg::BIT_DONE] & status_next[dkrf_pkg::BIT_DONE]) |
                          (cmd_reg[dkrf_pkg::BIT_VIOL] & status_next[dkrf_pkg::BIT_ERR]);
          pending_next = dkrf_pkg::OP_IDLE;
        end
        dkrf_pkg::OP_CLEAR: begin
          status_next  = st_keep | dkrf_pkg::ST_DONE;
          pending_next = dkrf_pkg::OP_IDLE;
        end
        default: ;
      endcase
    end else begin
      case (itm.opcode)
        dkrf_pkg::IOT_LOAD_CMD: begin
          if (busy) begin
            status_next = status | dkrf_pkg::ST_BUSY_VIOL;
          end else begin
            cmd_reg_next  = itm.bus_data;
            irq_flag_next = (itm.bus_data[dkrf_pkg::BIT_DONE] & status[dkrf_pkg::BIT_DONE]) |
                            (itm.bus_data[dkrf_pkg::BIT_VIOL] & status[dkrf_pkg::BIT_ERR]);
          end
          res.ac_out = '0;
        end
        dkrf_pkg::IOT_GO_READ, dkrf_pkg::IOT_GO_WRITE, dkrf_pkg::IOT_GO_CHECK: begin
          if (busy) begin
            status_next = status | dkrf_pkg::ST_BUSY_VIOL;
          end else if (!err) begin
            disk_addr_next = itm.bus_data;
            if (itm.opcode == dkrf_pkg::IOT_GO_READ) begin
              res.start_op = dkrf_pkg::OP_READ;
            end else if (itm.opcode == dkrf_pkg::IOT_GO_WRITE) begin
              res.start_op = dkrf_pkg::OP_WRITE;
            end else begin
              res.start_op = dkrf_pkg::OP_CHECK;
            end
            pending_next  = res.start_op;
            status_next   = dkrf_pkg::ST_BUSY;
            irq_flag_next = 1'b0;
          end
          res.ac_out = '0;
        end
        dkrf_pkg::IOT_RD_DA:   res.ac_out = disk_addr;
        dkrf_pkg::IOT_RD_CMD:  res.ac_out = cmd_reg;
        dkrf_pkg::IOT_RD_STAT: res.ac_out = status;
        dkrf_pkg::IOT_CLR_STAT: begin
          if (busy) begin
            status_next = status | dkrf_pkg::ST_BUSY_VIOL;
          end else begin
            status_next   = '0;
            irq_flag_next = 1'b0;
          end
        end
        dkrf_pkg::IOT_SKIP_DONE: res.skip = status[dkrf_pkg::BIT_DONE];
        dkrf_pkg::IOT_SKIP_ERR:  res.skip = err;
        dkrf_pkg::IOT_CLR_ALL: begin
          if (busy) begin
            status_next = status | dkrf_pkg::ST_BUSY_VIOL;
          end else if (!err) begin
            disk_addr_next = '0;
            cmd_reg_next   = cmd_reg & 12'o0006;
            neg_wc_next    = '0;
            mem_addr_next  = '0;
            res.start_op   = dkrf_pkg::OP_CLEAR;
            pending_next   = dkrf_pkg::OP_CLEAR;
            status_next    = dkrf_pkg::ST_BUSY;
            irq_flag_next  = 1'b0;
          end
        end
        dkrf_pkg::IOT_RD_WC: res.ac_out = neg_wc;
        dkrf_pkg::IOT_LOAD_WC: begin
          if (busy) begin
            status_next = status | dkrf_pkg::ST_BUSY_VIOL;
          end else begin
            neg_wc_next = itm.bus_data;
          end
          res.ac_out = '0;
        end
        dkrf_pkg::IOT_LOAD_MA: begin
          if (busy) begin
            status_next = status | dkrf_pkg::ST_BUSY_VIOL;
          end else begin
            mem_addr_next = itm.bus_data;
          end
          res.ac_out = '0;
        end
        dkrf_pkg::IOT_RD_MA: res.ac_out = mem_addr;
        default: res.unsupported = 1'b1;
      endcase
    end

    res.irq      = irq_flag_next;
    res.busy_res = status_next[dkrf_pkg::BIT_BUSY];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_mask <= 4'hf;
      wlock_mask <= 4'h0;
    end else if (cfg_write) begin
      if (cfg_index == dkrf_pkg::CFG_DRIVE_PRESENT) begin
        drive_mask <= cfg_data;
      end else begin
        wlock_mask <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_reg   <= '0;
      disk_addr <= '0;
      mem_addr  <= '0;
      neg_wc    <= '0;
      status    <= '0;
      irq_flag  <= 1'b0;
      pending   <= dkrf_pkg::OP_IDLE;
    end else if (go) begin
      cmd_reg   <= cmd_reg_next;
      disk_addr <= disk_addr_next;
      mem_addr  <= mem_addr_next;
      neg_wc    <= neg_wc_next;
      status    <= status_next;
      irq_flag  <= irq_flag_next;
      pending   <= pending_next;
    end
  end

endmodule

[hw/rtl/dkrf_out_reg.sv]
module dkrf_out_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  dkrf_pkg::res_t  res_in,
  input  logic            stall,
  output logic            valid,
  output dkrf_pkg::res_t  res_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

[hw/rtl/disk_controller_register_file_top.sv]
// Channel   Handshake                     Payload
// item      item_valid / item_stall       command opcode bus_data disk_fault words_done
// result    result_valid / result_stall   ac_out skip unsupported irq busy_res start_op
// config    cfg_write                     cfg_index cfg_data
//
// One item per cycle sustained while result_stall is low; a transfer lands in the input register
// on the accepting edge and moves to the result register when the update pass advances (one pass of update logic).
// Reset clears all controller registers, drive present mask to 4'hf, write lock mask to 0.
// A stalled result holds the update pass; the input register then fills and item_stall rises.
module disk_controller_register_file_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        command,
  input  logic [11:0] opcode,
  input  logic [11:0] bus_data,
  input  logic        disk_fault,
  input  logic [12:0] words_done,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [11:0] ac_out,
  output logic        skip,
  output logic        unsupported,
  output logic        irq,
  output logic        busy_res,
  output logic [2:0]  start_op,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);

  logic            item_full;
  dkrf_pkg::item_t item_q;
  logic            accept;
  logic            advance;
  dkrf_pkg::res_t  res_d;
  dkrf_pkg::res_t  res_q;

  assign advance    = item_full && (!result_valid || !result_stall);
  assign item_stall = item_full && !advance;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (accept) begin
      item_full <= 1'b1;
    end else if (advance) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q.command    <= command;
      item_q.opcode     <= opcode;
      item_q.bus_data   <= bus_data;
      item_q.disk_fault <= disk_fault;
      item_q.words_done <= words_done;
    end
  end

  dkrf_core u_core (
    .clk       (clk),
    .rst       (rst),
    .go        (advance),
    .itm       (item_q),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res_d)
  );

  dkrf_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (advance),
    .res_in  (res_d),
    .stall   (result_stall),
    .valid   (result_valid),
    .res_out (res_q)
  );

  assign ac_out      = res_q.ac_out;
  assign skip        = res_q.skip;
  assign unsupported = res_q.unsupported;
  assign irq         = res_q.irq;
  assign busy_res    = res_q.busy_res;
  assign start_op    = res_q.start_op;

  // a started operation always leaves the controller busy with no interrupt
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && (start_op != dkrf_pkg::OP_IDLE) |-> busy_res && !irq)
    else $error("start without busy or with irq");

  a_unsup_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && unsupported |-> (start_op == dkrf_pkg::OP_IDLE) && !skip)
    else $error("unsupported opcode had side effects");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !item_full |-> !item_stall)
    else $error("stall with empty input register");

  a_advance_valid: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("update pass lost its result");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import dkrf_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_ITEMS = 100;

  typedef struct {
    bit   pinned;
    res_t want;
  } pin_note_t;

  typedef struct {
    item_t it;
    bit    pinned;
    res_t  want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid;
  logic        item_stall;
  logic        command;
  logic [11:0] opcode;
  logic [11:0] bus_data;
  logic        disk_fault;
  logic [12:0] words_done;
  logic        result_valid;
  logic        result_stall;
  logic [11:0] ac_out;
  logic        skip;
  logic        unsupported;
  logic        irq;
  logic        busy_res;
  logic [2:0]  start_op;
  logic        cfg_write;
  logic        cfg_index;
  logic [3:0]  cfg_data;

  disk_controller_register_file_top uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the controller registers
  logic [11:0] sh_cmd, sh_da, sh_ma, sh_wc, sh_stat;
  logic        sh_irq;
  logic [2:0]  sh_pend;
  logic [3:0]  sh_present, sh_wlock;

  res_t      resp_q[$];
  pin_note_t pin_q[$];
  dir_row_t  dir_rows[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int n_err = 0;
  int n_items = 0;
  int quiet = 0;
  bit hold_req = 1'b0;

  function automatic res_t next_response(item_t it);
    res_t       r;
    logic       busy, err;
    logic [1:0] drv;
    int         wcnt, sum;
    busy = sh_stat[BIT_BUSY];
    err = sh_stat[BIT_ERR];
    r = '0;
    r.ac_out = it.bus_data;
    r.start_op = OP_IDLE;
    if (it.command == KIND_FINISH) begin
      r.ac_out = '0;
      if (sh_pend == OP_READ || sh_pend == OP_WRITE || sh_pend == OP_CHECK) begin
        wcnt = int'(FULL_COUNT) - int'(sh_wc);  // zero count means a full 4096
        drv = sh_cmd[2:1];
        if (int'(sh_da) + (wcnt + 255) / 256 > int'(NBLKS)) begin
          sh_stat = (sh_stat & ST_BUSY_VIOL) | ST_TRACK_ERR;
        end else if (int'(sh_ma) + wcnt > int'(FULL_COUNT)) begin
          sh_stat = (sh_stat & ST_BUSY_VIOL) | ST_RATE_ERR;
        end else if (!sh_present[drv]) begin
          sh_stat = (sh_stat & ST_BUSY_VIOL) | ST_SEL_ERR;
        end else begin
          sh_stat = (sh_stat & ST_BUSY_VIOL) | ST_DONE;
          if (!sh_cmd[BIT_NO_XFER]) begin
            if (sh_pend == OP_WRITE && sh_wlock[drv]) begin
              sh_stat = (sh_stat & ST_BUSY_VIOL) | ST_WLOCK_ERR;
              wcnt = 0;
            end else if (it.disk_fault) begin
              sh_stat = (sh_stat & ST_BUSY_VIOL) | ST_PAR_ERR;
              if (int'(it.words_done) < wcnt) wcnt = int'(it.words_done);
            end
            sum = int'(sh_da) + wcnt / 256;
            sh_da = sum[11:0];
            sum = int'(sh_ma) + wcnt;
            sh_ma = sum[11:0];
            sum = int'(sh_wc) + wcnt;
            sh_wc = sum[11:0];
          end
        end
        // command bit 10 enables irq on done, bit 9 on error
        sh_irq = (sh_cmd[BIT_DONE] & sh_stat[BIT_DONE]) | (sh_cmd[BIT_VIOL] & sh_stat[BIT_ERR]);
        sh_pend = OP_IDLE;
      end else if (sh_pend == OP_CLEAR) begin
        sh_stat = (sh_stat & ST_BUSY_VIOL) | ST_DONE;
        sh_pend = OP_IDLE;
      end
    end else begin
      case (it.opcode)
        IOT_LOAD_CMD: begin
          if (busy) begin
            sh_stat[BIT_VIOL] = 1'b1;
          end else begin
            sh_cmd = it.bus_data;
            sh_irq = (sh_cmd[BIT_DONE] & sh_stat[BIT_DONE]) |
                     (sh_cmd[BIT_VIOL] & sh_stat[BIT_ERR]);
          end
          r.ac_out = '0;
        end
        IOT_GO_READ, IOT_GO_WRITE, IOT_GO_CHECK: begin
          if (busy) begin
            sh_stat[BIT_VIOL] = 1'b1;
          end else if (!err) begin
            sh_da = it.bus_data;
            sh_irq = 1'b0;
            sh_stat = ST_BUSY;
            if (it.opcode == IOT_GO_READ) sh_pend = OP_READ;
            else if (it.opcode == IOT_GO_WRITE) sh_pend = OP_WRITE;
            else sh_pend = OP_CHECK;
            r.start_op = sh_pend;
          end
          r.ac_out = '0;
        end
        IOT_RD_DA:  r.ac_out = sh_da;
        IOT_RD_CMD: r.ac_out = sh_cmd;
        IOT_RD_STAT: r.ac_out = sh_stat;
        IOT_CLR_STAT: begin
          if (busy) begin
            sh_stat[BIT_VIOL] = 1'b1;
          end else begin
            sh_stat = '0;
            sh_irq = 1'b0;
          end
        end
        IOT_SKIP_DONE: r.skip = sh_stat[BIT_DONE];
        IOT_SKIP_ERR:  r.skip = err;
        IOT_CLR_ALL: begin
          if (busy) begin
            sh_stat[BIT_VIOL] = 1'b1;
          end else if (!err) begin
            sh_da = '0;
            sh_cmd = sh_cmd & 12'o0006;  // drive select survives
            sh_wc = '0;
            sh_ma = '0;
            sh_irq = 1'b0;
            sh_stat = ST_BUSY;
            sh_pend = OP_CLEAR;
            r.start_op = OP_CLEAR;
          end
        end
        IOT_RD_WC: r.ac_out = sh_wc;
        IOT_LOAD_WC: begin
          if (busy) sh_stat[BIT_VIOL] = 1'b1;
          else sh_wc = it.bus_data;
          r.ac_out = '0;
        end
        IOT_LOAD_MA: begin
          if (busy) sh_stat[BIT_VIOL] = 1'b1;
          else sh_ma = it.bus_data;
          r.ac_out = '0;
        end
        IOT_RD_MA: r.ac_out = sh_ma;
        default: r.unsupported = 1'b1;
      endcase
    end
    r.irq = sh_irq;
    r.busy_res = sh_stat[BIT_BUSY];
    return r;
  endfunction

  function automatic res_t resp(logic [11:0] ac, logic sk, logic un, logic iq, logic bz,
                                logic [2:0] op);
    res_t r;
    r.ac_out = ac;
    r.skip = sk;
    r.unsupported = un;
    r.irq = iq;
    r.busy_res = bz;
    r.start_op = op;
    return r;
  endfunction

  function automatic logic [11:0] rnd12();
    int v;
    v = $urandom;
    return v[11:0];
  endfunction

  function automatic logic [3:0] rnd4();
    int v;
    v = $urandom_range(15);
    return v[3:0];
  endfunction

  function automatic item_t iot_item(logic [11:0] op, logic [11:0] ac);
    item_t it;
    int    w;
    int    f;
    w = $urandom_range(4096);
    f = $urandom_range(1);
    it.command = KIND_IOT;
    it.opcode = op;
    it.bus_data = ac;
    it.disk_fault = f[0];
    it.words_done = w[12:0];
    return it;
  endfunction

  function automatic item_t fin_item(logic fault, int wd);
    item_t it;
    it.command = KIND_FINISH;
    it.opcode = rnd12();
    it.bus_data = rnd12();
    it.disk_fault = fault;
    it.words_done = wd[12:0];
    return it;
  endfunction

  function automatic logic [11:0] pick_iot(bit reads_only);
    int k;
    k = reads_only ? $urandom_range(6) : $urandom_range(14);
    case (k)
      0: return IOT_RD_STAT;
      1: return IOT_SKIP_DONE;
      2: return IOT_SKIP_ERR;
      3: return IOT_RD_DA;
      4: return IOT_RD_MA;
      5: return IOT_RD_WC;
      6: return IOT_RD_CMD;
      7: return IOT_LOAD_CMD;
      8: return IOT_GO_READ;
      9: return IOT_GO_WRITE;
      10: return IOT_GO_CHECK;
      11: return IOT_CLR_STAT;
      12: return IOT_CLR_ALL;
      13: return IOT_LOAD_WC;
      default: return IOT_LOAD_MA;
    endcase
  endfunction

  task automatic add_row(item_t it, bit pinned, res_t want);
    dir_row_t r;
    r.it = it;
    r.pinned = pinned;
    r.want = want;
    dir_rows.push_back(r);
  endtask

  // offer one item and hold it until the transfer happens
  task automatic send(item_t it, bit pinned, res_t want);
    pin_note_t nt;
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    nt.pinned = pinned;
    nt.want = want;
    pin_q.push_back(nt);
    item_valid <= 1'b1;
    command <= it.command;
    opcode <= it.opcode;
    bus_data <= it.bus_data;
    disk_fault <= it.disk_fault;
    words_done <= it.words_done;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic issue(item_t it);
    send(it, 1'b0, '0);
    n_items++;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (resp_q.size() != 0);
  endtask

  task automatic set_masks(logic [3:0] present, logic [3:0] wlock);
    cfg_write <= 1'b1;
    cfg_index <= CFG_DRIVE_PRESENT;
    cfg_data <= present;
    @(posedge clk);
    cfg_index <= CFG_WRITE_LOCK;
    cfg_data <= wlock;
    @(posedge clk);
    cfg_write <= 1'b0;
    sh_present = present;
    sh_wlock = wlock;
  endtask

  task automatic rand_burst();
    int          sel, n, v, wd;
    logic [11:0] cmdw, go_op;
    sel = $urandom_range(99);
    if (sel < 70) begin
      // full transfer: set up, start, maybe poke while busy, complete, read back
      if ($urandom_range(99) < 80) issue(iot_item(IOT_CLR_STAT, rnd12()));
      cmdw = rnd12();
      cmdw[BIT_NO_XFER] = ($urandom_range(99) < 15);
      issue(iot_item(IOT_LOAD_CMD, cmdw));
      v = $urandom_range(99);
      if (v < 70) n = $urandom_range(600, 1);
      else if (v < 85) n = 4096;
      else n = $urandom_range(4096, 1);
      v = 4096 - n;
      issue(iot_item(IOT_LOAD_WC, v[11:0]));
      v = ($urandom_range(99) < 70) ? $urandom_range(3000) : $urandom_range(4095);
      issue(iot_item(IOT_LOAD_MA, v[11:0]));
      case ($urandom_range(2))
        0: go_op = IOT_GO_READ;
        1: go_op = IOT_GO_WRITE;
        default: go_op = IOT_GO_CHECK;
      endcase
      v = ($urandom_range(99) < 80) ? $urandom_range(3300) : $urandom_range(4095);
      issue(iot_item(go_op, v[11:0]));
      if ($urandom_range(99) < 30)
        repeat ($urandom_range(3, 1)) issue(iot_item(pick_iot(1'b0), rnd12()));
      wd = ($urandom_range(99) < 50) ? $urandom_range(4096) : $urandom_range(700);
      issue(fin_item($urandom_range(99) < 30, wd));
      repeat ($urandom_range(4, 1)) issue(iot_item(pick_iot(1'b1), rnd12()));
    end else if (sel < 82) begin
      issue(iot_item(IOT_CLR_STAT, rnd12()));
      issue(iot_item(IOT_CLR_ALL, rnd12()));
      if ($urandom_range(99) < 30) issue(iot_item(pick_iot(1'b0), rnd12()));
      issue(fin_item($urandom_range(99) < 50, $urandom_range(4096)));
      issue(iot_item(pick_iot(1'b1), rnd12()));
    end else begin
      // noise: stray completions, random opcodes, arbitrary device codes
      repeat ($urandom_range(3, 1)) begin
        if ($urandom_range(99) < 25)
          issue(fin_item($urandom_range(99) < 50, $urandom_range(4096)));
        else if ($urandom_range(1))
          issue(iot_item(pick_iot(1'b0), rnd12()));
        else
          issue(iot_item(rnd12(), rnd12()));
      end
    end
  endtask

  // accepted items feed the predictor, accepted results are checked in order
  always @(posedge clk) begin : monitor
    item_t     it;
    res_t      got, want, pred;
    pin_note_t nt;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        got = resp(ac_out, skip, unsupported, irq, busy_res, start_op);
        if (resp_q.size() == 0) begin
          if (n_err < 10) $display("unexpected result: ac_out=%o", ac_out);
          n_err++;
        end else begin
          want = resp_q.pop_front();
          if (got !== want) begin
            if (n_err < 10)
              $display("exp/act ac %o/%o sk %b/%b un %b/%b irq %b/%b bz %b/%b op %0d/%0d",
                       want.ac_out, got.ac_out, want.skip, got.skip,
                       want.unsupported, got.unsupported, want.irq, got.irq,
                       want.busy_res, got.busy_res, want.start_op, got.start_op);
            n_err++;
          end
        end
      end
      if (item_valid && !item_stall) begin
        it.command = command;
        it.opcode = opcode;
        it.bus_data = bus_data;
        it.disk_fault = disk_fault;
        it.words_done = words_done;
        pred = next_response(it);
        nt = pin_q.pop_front();
        resp_q.push_back(nt.pinned ? nt.want : pred);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) || cfg_write) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no transfer in %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // result side: random stall, or a long hold-off on request
  initial begin
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    int ph, target;
    item_valid = 1'b0;
    command = KIND_IOT;
    opcode = '0;
    bus_data = '0;
    disk_fault = 1'b0;
    words_done = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_DRIVE_PRESENT;
    cfg_data = '0;
    sh_cmd = '0;
    sh_da = '0;
    sh_ma = '0;
    sh_wc = '0;
    sh_stat = '0;
    sh_irq = 1'b0;
    sh_pend = OP_IDLE;
    sh_present = 4'hf;
    sh_wlock = 4'h0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    add_row(iot_item(IOT_RD_STAT, 12'o7777), 1'b1,
            resp(12'o0000, 1'b0, 1'b0, 1'b0, 1'b0, OP_IDLE));
    // not device codes
    add_row(iot_item(12'o0000, 12'o7777), 1'b1,
            resp(12'o7777, 1'b0, 1'b1, 1'b0, 1'b0, OP_IDLE));
    add_row(iot_item(12'o7777, 12'o0000), 1'b1,
            resp(12'o0000, 1'b0, 1'b1, 1'b0, 1'b0, OP_IDLE));
    // completion with nothing started
    add_row(fin_item(1'b1, 4096), 1'b1,
            resp(12'o0000, 1'b0, 1'b0, 1'b0, 1'b0, OP_IDLE));
    add_row(iot_item(IOT_SKIP_DONE, 12'o5252), 1'b1,
            resp(12'o5252, 1'b0, 1'b0, 1'b0, 1'b0, OP_IDLE));
    add_row(iot_item(IOT_LOAD_CMD, 12'o3000), 1'b1,
            resp(12'o0000, 1'b0, 1'b0, 1'b0, 1'b0, OP_IDLE));
    add_row(iot_item(IOT_LOAD_WC, 12'o7400), 1'b1,
            resp(12'o0000, 1'b0, 1'b0, 1'b0, 1'b0, OP_IDLE));
    add_row(iot_item(IOT_LOAD_MA, 12'o0000), 1'b1,
            resp(12'o0000, 1'b0, 1'b0, 1'b0, 1'b0, OP_IDLE));
    add_row(iot_item(IOT_GO_READ, 12'o0000), 1'b1,
            resp(12'o0000, 1'b0, 1'b0, 1'b0, 1'b1, OP_READ));
    // load while busy flags a busy violation
    add_row(iot_item(IOT_LOAD_MA, 12'o7777), 1'b1,
            resp(12'o0000, 1'b0, 1'b0, 1'b0, 1'b1, OP_IDLE));
    add_row(iot_item(IOT_RD_STAT, 12'o0000), 1'b1,
            resp(12'o1001, 1'b0, 1'b0, 1'b0, 1'b1, OP_IDLE));
    // faulted read, words moved above the count get clamped
    add_row(fin_item(1'b1, 4096), 1'b0, '0);
    add_row(iot_item(IOT_SKIP_ERR, 12'o0000), 1'b0, '0);
    // start with error set is dropped
    add_row(iot_item(IOT_GO_WRITE, 12'o0000), 1'b0, '0);
    add_row(iot_item(IOT_RD_WC, 12'o1234), 1'b0, '0);
    add_row(iot_item(IOT_CLR_STAT, 12'o0000), 1'b1,
            resp(12'o0000, 1'b0, 1'b0, 1'b0, 1'b0, OP_IDLE));
    // zero count (full 4096) from block 7777 (octal) runs off the disk
    add_row(iot_item(IOT_GO_WRITE, 12'o7777), 1'b1,
            resp(12'o0000, 1'b0, 1'b0, 1'b0, 1'b1, OP_WRITE));
    add_row(fin_item(1'b0, 0), 1'b0, '0);
    add_row(iot_item(IOT_RD_STAT, 12'o0000), 1'b0, '0);
    add_row(iot_item(IOT_CLR_STAT, 12'o0000), 1'b1,
            resp(12'o0000, 1'b0, 1'b0, 1'b0, 1'b0, OP_IDLE));
    add_row(iot_item(IOT_LOAD_MA, 12'o0000), 1'b1,
            resp(12'o0000, 1'b0, 1'b0, 1'b0, 1'b0, OP_IDLE));
    // seek only
    add_row(iot_item(IOT_LOAD_CMD, 12'o0200), 1'b1,
            resp(12'o0000, 1'b0, 1'b0, 1'b0, 1'b0, OP_IDLE));
    add_row(iot_item(IOT_GO_CHECK, 12'o0100), 1'b1,
            resp(12'o0000, 1'b0, 1'b0, 1'b0, 1'b1, OP_CHECK));
    add_row(fin_item(1'b0, 0), 1'b0, '0);
    add_row(iot_item(IOT_CLR_ALL, 12'o1234), 1'b1,
            resp(12'o1234, 1'b0, 1'b0, 1'b0, 1'b1, OP_CLEAR));
    add_row(fin_item(1'b0, 0), 1'b0, '0);
    foreach (dir_rows[i]) send(dir_rows[i].it, dir_rows[i].pinned, dir_rows[i].want);
    drain();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  set_masks(4'hf, 4'h0); end
        1: begin idle_pct = 67; stall_pct = 0;  set_masks(4'h0, 4'hf); end
        2: begin idle_pct = 0;  stall_pct = 67; set_masks(rnd4(), rnd4()); end
        3: begin idle_pct = 6;  stall_pct = 6;  set_masks(4'hf, 4'hf); end
        4: begin idle_pct = 0;  stall_pct = 0;  set_masks(rnd4(), rnd4()); end
        default: begin idle_pct = 6; stall_pct = 6; set_masks(rnd4(), rnd4()); end
      endcase
      // back-pressure: results held off while items keep coming
      if (ph == 0) begin
        hold_req = 1'b1;
        repeat (5) rand_burst();
      end
      target = n_items + PHASE_ITEMS;
      while (n_items < target) rand_burst();
      drain();
    end

    repeat (5) @(posedge clk);
    if (n_err == 0 && resp_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/dkrf_pkg.sv
hw/rtl/dkrf_core.sv
hw/rtl/dkrf_out_reg.sv
hw/rtl/disk_controller_register_file_top.sv
dv/tb.sv
